// ===== rtl/core/i2cbs_pkg.sv =====
// Shared types and constants for the I2C master byte sequencer.
package i2cbs_pkg;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [15:0] BIT_DELAY_RESET = 16'd16;

  // Command codes match the action field encoding.
  typedef enum logic [2:0] {
    CMD_INIT  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_WRITE = 3'd3,
    CMD_READ  = 3'd4
  } cmd_e_t;

  typedef struct packed {
    cmd_e_t      op;
    logic [7:0]  tx_byte;
    logic        send_ack;
    logic [7:0]  data_samples;
    logic        ack_sample;
  } cmd_item_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_HOLD,
    BK_SHOW
  } back_state_t;

endpackage

// ===== rtl/core/i2c_master_byte_sequencer_unit.sv =====
// Top level of the I2C master byte sequencer.
//
// Usage: each request on the input channel (in_valid/in_stall) carries one
// command: init, start, stop, write byte or read byte. Actions 5 to 7 are
// accepted and discarded without any result. Each command produces a run of
// results on the output channel (out_valid/out_stall), one per bus phase,
// giving the SCL level, the SDA level and whether the master drives SDA.
// The last phase of a command is flagged; it carries the read byte for a
// read and the sampled acknowledge for a write.
// Timing: every phase is held while the hold counter, loaded from bit_delay,
// counts down, and is then offered until it is taken; the sequencer passes
// through idle between commands. A write takes 26 phases, a read 20, init 1,
// start 3 and stop 2. A two-entry command queue lets new requests be taken
// while the sequencer is still working or waiting on a stalled result.
// A stalled result holds all its fields and the sequencer waits; once the
// queue is full, in_stall goes high. bit_delay is written over the cfg
// channel, which is always ready; it must be written only while the block
// is idle, and the block itself does not enforce this.
// Reset (rst, synchronous) empties the queue, sets bit_delay to 16 and puts
// the pins at SCL high, SDA high and SDA released.
module i2c_master_byte_sequencer_unit import i2cbs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] bit_delay,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  action,
  input  logic [7:0]  tx_byte,
  input  logic        send_ack,
  input  logic [7:0]  data_samples,
  input  logic        ack_sample,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        scl_level,
  output logic        sda_level,
  output logic        sda_drive,
  output logic        last_phase,
  output logic [7:0]  rx_byte,
  output logic        ack_seen
);

  logic              push;
  cmd_item_t         push_item;
  logic              pop;
  logic              q_valid;
  logic              q_full;
  cmd_item_t         head;
  logic [QCNT_W-1:0] q_count;

  assign cfg_ready = 1'b1;

  i2cbs_front u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .tx_byte      (tx_byte),
    .send_ack     (send_ack),
    .data_samples (data_samples),
    .ack_sample   (ack_sample),
    .q_full       (q_full),
    .push         (push),
    .push_item    (push_item)
  );

  i2cbs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_full    (q_full),
    .head      (head),
    .count     (q_count)
  );

  i2cbs_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_data   (bit_delay),
    .q_valid    (q_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .scl_level  (scl_level),
    .sda_level  (sda_level),
    .sda_drive  (sda_drive),
    .last_phase (last_phase),
    .rx_byte    (rx_byte),
    .ack_seen   (ack_seen)
  );

  // Read byte and acknowledge appear only on the final phase of a command.
  a_status_on_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_phase |-> rx_byte == 8'd0 && !ack_seen)
    else $error("status fields set on a non-final phase");

  // Nothing is offered in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered right after reset");

  // The input side stalls only when the queue is really full.
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> q_count == QCNT_W'(QDEPTH))
    else $error("input stalled with room in the queue");

  // No command is pushed into a full queue, so none is lost.
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !push)
    else $error("push into a full queue");

endmodule

// ===== rtl/core/i2cbs_front.sv =====
// Front end: accepts requests, drops unknown actions, pushes commands.
module i2cbs_front import i2cbs_pkg::*; (
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [2:0]      action,
  input  logic [7:0]      tx_byte,
  input  logic            send_ack,
  input  logic [7:0]      data_samples,
  input  logic            ack_sample,
  input  logic            q_full,
  output logic            push,
  output cmd_item_t       push_item
);

  logic known;

  always_comb begin
    unique case (action)
      CMD_INIT, CMD_START, CMD_STOP, CMD_WRITE, CMD_READ: known = 1'b1;
      default: known = 1'b0;
    endcase
  end

  assign in_stall = q_full;
  // Unknown actions are taken and discarded; they produce no bus phases.
  assign push = in_valid && !q_full && known;

  always_comb begin
    push_item.op           = cmd_e_t'(action);
    push_item.tx_byte      = tx_byte;
    push_item.send_ack     = send_ack;
    push_item.data_samples = data_samples;
    push_item.ack_sample   = ack_sample;
  end

endmodule

// ===== rtl/core/i2cbs_queue.sv =====
// Short command queue between the front end and the bus sequencer.
module i2cbs_queue import i2cbs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  cmd_item_t         push_item,
  input  logic              pop,
  output logic              q_valid,
  output logic              q_full,
  output cmd_item_t         head,
  output logic [QCNT_W-1:0] count
);

  cmd_item_t         entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;

  assign q_valid = (count != '0);
  assign q_full  = (count == QCNT_W'(QDEPTH));
  assign head    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

// ===== rtl/core/i2cbs_back.sv =====
// Bus sequencer: walks each command through its pin phases and holds each phase.
module i2cbs_back import i2cbs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  input  logic        q_valid,
  input  cmd_item_t   head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        scl_level,
  output logic        sda_level,
  output logic        sda_drive,
  output logic        last_phase,
  output logic [7:0]  rx_byte,
  output logic        ack_seen
);

  back_state_t state;
  back_state_t state_next;
  logic [15:0] bit_delay;
  logic [15:0] dcnt;
  cmd_item_t   cur;
  logic [7:0]  tx_sh;
  logic [1:0]  sub;
  logic [3:0]  bitcnt;
  logic        scl_r;
  logic        sda_r;
  logic        en_r;

  logic nscl, nsda, nen, last, sub_end, rb_done, do_wb, do_rb, wb_val;
  logic accept;

  // Phase decode: the pin levels after this phase's update.
  always_comb begin
    nscl    = scl_r;
    nsda    = sda_r;
    nen     = en_r;
    last    = 1'b0;
    sub_end = 1'b0;
    rb_done = 1'b0;
    do_wb   = 1'b0;
    do_rb   = 1'b0;
    wb_val  = 1'b0;
    unique case (cur.op)
      CMD_INIT: begin
        nen  = 1'b1;
        nscl = 1'b1;
        nsda = 1'b1;
        last = 1'b1;
      end
      CMD_START: begin
        unique case (sub)
          2'd0: begin
            nscl = 1'b1;
            nsda = 1'b1;
          end
          2'd1: nsda = 1'b0;
          default: begin
            nscl = 1'b0;
            last = 1'b1;
          end
        endcase
      end
      CMD_STOP: begin
        if (sub == 2'd0) begin
          nscl = 1'b1;
        end else begin
          nsda = 1'b1;
          last = 1'b1;
        end
      end
      CMD_WRITE: begin
        if (!bitcnt[3]) begin
          do_wb  = 1'b1;
          wb_val = tx_sh[7];
        end else begin
          do_rb = 1'b1;
          last  = sub[0];
        end
      end
      CMD_READ: begin
        if (!bitcnt[3]) begin
          do_rb = 1'b1;
        end else if (!bitcnt[0]) begin
          do_wb  = 1'b1;
          wb_val = !cur.send_ack;
        end else begin
          last = 1'b1;
        end
      end
      default: last = 1'b1;
    endcase

    if (do_wb) begin
      unique case (sub)
        2'd0: begin
          nsda = wb_val;
          nscl = 1'b1;
        end
        2'd1: nscl = 1'b0;
        default: begin
          nsda    = 1'b0;
          sub_end = 1'b1;
        end
      endcase
    end
    if (do_rb) begin
      if (sub == 2'd0) begin
        nsda = 1'b1;
        nscl = 1'b1;
        nen  = 1'b0;
      end else begin
        nscl    = 1'b0;
        sub_end = 1'b1;
        rb_done = 1'b1;
      end
    end
  end

  assign scl_level  = nscl;
  assign sda_level  = nsda;
  assign sda_drive  = nen;
  assign last_phase = last;
  assign rx_byte    = (last && cur.op == CMD_READ) ? cur.data_samples : 8'd0;
  assign ack_seen   = last && cur.op == CMD_WRITE && cur.ack_sample;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: if (q_valid) state_next = BK_HOLD;
      BK_HOLD: if (dcnt <= 16'd1) state_next = BK_SHOW;
      BK_SHOW: if (!out_stall) state_next = last ? BK_IDLE : BK_HOLD;
      default: state_next = BK_IDLE;
    endcase
  end

  // Outputs of the state machine.
  always_comb begin
    pop       = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      BK_IDLE: pop = q_valid;
      BK_SHOW: out_valid = 1'b1;
      default: begin
        pop       = 1'b0;
        out_valid = 1'b0;
      end
    endcase
  end

  assign accept = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      bit_delay <= BIT_DELAY_RESET;
      scl_r     <= 1'b1;
      sda_r     <= 1'b1;
      en_r      <= 1'b0;
      sub       <= '0;
      bitcnt    <= '0;
      dcnt      <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        bit_delay <= cfg_data;
      end
      if (pop) begin
        dcnt   <= bit_delay;
        sub    <= '0;
        bitcnt <= '0;
      end else if (state == BK_HOLD) begin
        dcnt <= dcnt - 1'b1;
      end
      if (accept) begin
        scl_r <= nscl;
        sda_r <= nsda;
        // SDA is driven again once a read bit's clock pulse ends.
        en_r  <= rb_done ? 1'b1 : nen;
        dcnt  <= bit_delay;
        if (last) begin
          sub    <= '0;
          bitcnt <= '0;
        end else if (sub_end) begin
          sub    <= '0;
          bitcnt <= bitcnt + 1'b1;
        end else begin
          sub <= sub + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur   <= head;
      tx_sh <= head.tx_byte;
    end else if (accept && do_wb && sub_end) begin
      tx_sh <= {tx_sh[6:0], 1'b0};
    end
  end

endmodule
